// ===== src/slid_pkg.sv =====
// Shared types and constants of the staff-line interline detector.
`default_nettype none
package slid_pkg;

   localparam int GRAY_W   = 8;
   localparam int STRIDE_W = 3;
   localparam int COUNT_W  = 13;
   localparam int VALUE_W  = 14;
   localparam int BIN_W    = 14;

   localparam int ROW_BITS_DEF  = 14;
   localparam int HIST_BINS_DEF = 81;

   localparam int MIN_DISTANCE = 4;
   localparam int MIN_VOTES    = 4;
   localparam int STRIDE_MAX   = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [BIN_W-1:0]   BIN_MAX   = '1;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 3'd2;
   localparam logic [COUNT_W-1:0]  REQUIRED_RESET = 13'd16;
   localparam logic [GRAY_W-1:0]   LEVEL_RESET    = 8'd112;

   typedef enum logic [1:0] {
      REG_SAMPLE_STRIDE = 2'd0,
      REG_REQUIRED_DARK = 2'd1,
      REG_DARK_LEVEL    = 2'd2
   } reg_index_type;

   typedef enum logic {
      KIND_CENTER    = 1'b0,
      KIND_INTERLINE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_ROW,
      ST_CENTER,
      ST_INCR,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              row_end;
      logic              page_end;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/slid_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module slid_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 81
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/staff_line_interline_detector.sv =====
// Top level of the staff-line interline detector.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  request  | in        | req_valid / req_stall  | req_data: gray, row_end, page_end
//  result   | out       | rsp_valid / rsp_stall  | rsp_data: kind, value, last
//  config   | in        | APB psel/penable/...   | sample_stride, required_dark,
//           |           |                        | dark_level at 0x0, 0x4, 0x8
//
// A pixel that does not end its row is taken in ST_RUN. A row end passes through
// ST_ROW, then ST_CENTER when it closes a run of line rows, then ST_INCR when
// that close also bumps a histogram bin (read, then write back, through the
// single histogram RAM). A page end adds a scan over the histogram RAM, which
// finds the most frequent distance and zeroes each bin behind it, then ST_EMIT
// hands off the interline result.
// After reset a clearing pass zeroes the histogram RAM;
// no request is taken meanwhile (config writes still are).
// A stalled result holds in the output register; the block keeps taking pixels
// until it must push a second result, where it waits.
`default_nettype none
module staff_line_interline_detector
   import slid_pkg::*;
#(
   parameter int ROW_BITS  = ROW_BITS_DEF,
   parameter int HIST_BINS = HIST_BINS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int HA = $clog2(HIST_BINS);
   localparam logic [HA-1:0] LAST_BIN = HA'(HIST_BINS - 1);
   localparam logic [HA-1:0] MIN_BIN  = HA'(MIN_DISTANCE);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [STRIDE_W-1:0] stride_ff;
   logic [COUNT_W-1:0]  required_ff;
   logic [GRAY_W-1:0]   level_ff;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff   <= STRIDE_RESET;
         required_ff <= REQUIRED_RESET;
         level_ff    <= LEVEL_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(paddr[3:2]))
            REG_SAMPLE_STRIDE: stride_ff   <= pwdata[STRIDE_W-1:0];
            REG_REQUIRED_DARK: required_ff <= pwdata[COUNT_W-1:0];
            REG_DARK_LEVEL:    level_ff    <= pwdata[GRAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_SAMPLE_STRIDE: prdata = 32'(stride_ff);
         REG_REQUIRED_DARK: prdata = 32'(required_ff);
         REG_DARK_LEVEL:    prdata = 32'(level_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic                 in_run_ff, in_run_in;
   logic [ROW_BITS-1:0]  run_start_ff, run_start_in;
   logic [ROW_BITS-1:0]  prev_ff, prev_in;
   logic                 have_ff, have_in;
   logic                 peak_ff, peak_in;
   logic                 page_ff, page_in;
   logic [ROW_BITS-1:0]  center_ff, center_in;
   logic [HA-1:0]        incr_addr_ff, incr_addr_in;
   logic [HA-1:0]        scan_addr_ff, scan_addr_in;
   logic                 scan_pend_ff, scan_pend_in;
   logic [HA-1:0]        scan_rd_addr_ff, scan_rd_addr_in;
   logic [HA-1:0]        best_addr_ff, best_addr_in;
   logic [BIN_W-1:0]     best_cnt_ff, best_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // histogram RAM
   logic             ram_wr_en, ram_rd_en;
   logic [HA-1:0]    ram_wr_addr, ram_rd_addr;
   logic [BIN_W-1:0] ram_wr_data, ram_rd_data;

   slid_ram #(
      .WIDTH (BIN_W),
      .DEPTH (HIST_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Shared combinational terms
   // ---------------------------------------------------------------------------
   logic                accept;
   logic                row_done;
   logic                can_push;
   logic [STRIDE_W-1:0] stride_eff;
   logic [STRIDE_W-1:0] phase_inc;
   logic                dark_hit;
   logic [COUNT_W-1:0]  count_next;
   logic [ROW_BITS-1:0] start_sel;
   logic                close_run;
   logic [ROW_BITS-1:0] end_row;
   logic [ROW_BITS:0]   center_sum;
   logic [ROW_BITS-1:0] gap;
   logic                dist_ok;
   logic                best_take;
   logic                scan_zero;

   assign accept   = req_valid & ~req_stall;
   assign row_done = req_data.row_end | req_data.page_end;
   assign can_push = ~rsp_valid_ff | ~rsp_stall;

   // stride zero acts as one, above four as four
   assign stride_eff = (stride_ff == '0) ? STRIDE_W'(1) :
                       (stride_ff > STRIDE_W'(STRIDE_MAX)) ? STRIDE_W'(STRIDE_MAX) :
                       stride_ff;
   assign phase_inc  = STRIDE_W'(phase_ff) + STRIDE_W'(1);
   assign dark_hit   = (phase_ff == 2'd0) && (req_data.gray < level_ff) &&
                       (count_ff != COUNT_MAX);
   assign count_next = count_ff + COUNT_W'(dark_hit);

   // run bookkeeping at a row end (row_ff still holds the ending row)
   assign start_sel  = in_run_ff ? run_start_ff : row_ff;
   assign close_run  = peak_ff ? page_ff : in_run_ff;
   assign end_row    = peak_ff ? row_ff : row_ff - ROW_BITS'(1);
   assign center_sum = {1'b0, start_sel} + {1'b0, end_row};

   // distance to the previous center; only 4 .. HIST_BINS-1 is recorded
   assign gap     = center_ff - prev_ff;
   assign dist_ok = have_ff && (center_ff > prev_ff) &&
                    (gap >= ROW_BITS'(MIN_DISTANCE)) &&
                    ({1'b0, gap} < (ROW_BITS+1)'(HIST_BINS));

   // scan: first bin from MIN_DISTANCE on with the strictly largest count
   assign best_take = scan_pend_ff && (scan_rd_addr_ff >= MIN_BIN) &&
                      ((scan_rd_addr_ff == MIN_BIN) || (ram_rd_data > best_cnt_ff));
   assign scan_zero = (state_ff == ST_SCAN) || (state_ff == ST_SCAN_LAST);

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_addr_ff == LAST_BIN) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (accept && row_done) state_in = ST_ROW;
         end
         ST_ROW: begin
            if (close_run)    state_in = ST_CENTER;
            else if (page_ff) state_in = ST_SCAN;
            else              state_in = ST_RUN;
         end
         ST_CENTER: begin
            if (can_push) begin
               if (dist_ok)      state_in = ST_INCR;
               else if (page_ff) state_in = ST_SCAN;
               else              state_in = ST_RUN;
            end
         end
         ST_INCR: begin
            state_in = page_ff ? ST_SCAN : ST_RUN;
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST_BIN) state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_push) state_in = ST_RUN;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Outputs: handshake, RAM port controls
   // ---------------------------------------------------------------------------
   always_comb begin
      req_stall   = (state_ff != ST_RUN);
      ram_wr_en   = 1'b0;
      ram_wr_addr = scan_addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_CENTER: begin
            ram_rd_en   = can_push & dist_ok;
            ram_rd_addr = HA'(gap);
         end
         ST_INCR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = incr_addr_ff;
            ram_wr_data = (ram_rd_data == BIN_MAX) ? ram_rd_data
                                                   : ram_rd_data + BIN_W'(1);
         end
         ST_SCAN: begin
            ram_rd_en = 1'b1;
         end
         default: ;
      endcase
      // each bin is zeroed the cycle after it is read
      if (scan_zero && scan_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = scan_rd_addr_ff;
         ram_wr_data = '0;
      end
   end

   // ---------------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------------
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      row_in          = row_ff;
      in_run_in       = in_run_ff;
      run_start_in    = run_start_ff;
      prev_in         = prev_ff;
      have_in         = have_ff;
      peak_in         = peak_ff;
      page_in         = page_ff;
      center_in       = center_ff;
      incr_addr_in    = incr_addr_ff;
      scan_addr_in    = scan_addr_ff;
      scan_pend_in    = 1'b0;
      scan_rd_addr_in = scan_addr_ff;
      best_addr_in    = best_addr_ff;
      best_cnt_in     = best_cnt_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_data_in     = rsp_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            scan_addr_in = (scan_addr_ff == LAST_BIN) ? '0 : scan_addr_ff + HA'(1);
         end
         ST_RUN: begin
            if (accept) begin
               if (row_done) begin
                  peak_in  = (count_next >= required_ff);
                  page_in  = req_data.page_end;
                  count_in = '0;
                  phase_in = 2'd0;
               end else begin
                  count_in = count_next;
                  phase_in = (phase_inc >= stride_eff) ? 2'd0 : phase_inc[1:0];
               end
            end
         end
         ST_ROW: begin
            if (peak_ff) begin
               run_start_in = start_sel;
               in_run_in    = ~page_ff;
            end else begin
               in_run_in = 1'b0;
            end
            center_in = center_sum[ROW_BITS:1];
            if (row_ff != '1) row_in = row_ff + ROW_BITS'(1);
         end
         ST_CENTER: begin
            if (can_push) begin
               prev_in      = center_ff;
               have_in      = 1'b1;
               incr_addr_in = HA'(gap);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind:  KIND_CENTER,
                                value: VALUE_W'(center_ff),
                                last:  1'b0};
            end
         end
         ST_SCAN: begin
            scan_pend_in    = 1'b1;
            scan_rd_addr_in = scan_addr_ff;
            scan_addr_in    = (scan_addr_ff == LAST_BIN) ? '0 : scan_addr_ff + HA'(1);
         end
         ST_EMIT: begin
            if (can_push) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind:  KIND_INTERLINE,
                                value: (best_cnt_ff < BIN_W'(MIN_VOTES)) ? '0
                                       : VALUE_W'(best_addr_ff),
                                last:  1'b1};
               // page done: back to the cleared state
               row_in       = '0;
               in_run_in    = 1'b0;
               run_start_in = '0;
               prev_in      = '0;
               have_in      = 1'b0;
            end
         end
         default: ;
      endcase

      if (best_take) begin
         best_addr_in = scan_rd_addr_ff;
         best_cnt_in  = ram_rd_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= '0;
         count_ff     <= '0;
         row_ff       <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         peak_ff      <= 1'b0;
         page_ff      <= 1'b0;
         scan_addr_ff <= '0;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         peak_ff      <= peak_in;
         page_ff      <= page_in;
         scan_addr_ff <= scan_addr_in;
         scan_pend_ff <= scan_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      center_ff       <= center_in;
      incr_addr_ff    <= incr_addr_in;
      scan_rd_addr_ff <= scan_rd_addr_in;
      best_addr_ff    <= best_addr_in;
      best_cnt_ff     <= best_cnt_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
